[design/gcsp_pkg.sv]
// Shared types, constants and the shelf placement function of the glyph cache shelf packer.
package gcsp_pkg;

  localparam int unsigned DEF_MAX_GLYPHS = 32;
  localparam int unsigned DEF_MAX_SIDE   = 4096;

  localparam int unsigned SIDE_W  = 13;
  localparam int unsigned DIM_W   = 12;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned FONT_W  = 8;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned GEN_W   = 8;
  localparam int unsigned OIDX_W  = 6;
  localparam int unsigned CFGI_W  = 2;
  // placement arithmetic is wide enough for fourteen doublings of a 13-bit side
  localparam int unsigned PW      = 28;
  localparam logic [3:0]  LAST_ITER = 4'd14;

  localparam logic [SIDE_W-1:0] RESET_SIDE = SIDE_W'(256);

  localparam logic [CFGI_W-1:0] REG_INIT_W = 2'd0;
  localparam logic [CFGI_W-1:0] REG_INIT_H = 2'd1;
  localparam logic [CFGI_W-1:0] REG_MONO   = 2'd2;

  typedef enum logic [2:0] {
    KIND_RELOC       = 3'd0,
    KIND_HIT         = 3'd1,
    KIND_PLACED      = 3'd2,
    KIND_FULL        = 3'd3,
    KIND_TOO_LARGE   = 3'd4,
    KIND_REPACK_FAIL = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PS_CUR, PS_GROW, PS_REP_ENTRY, PS_REP_NEW
  } place_sel_e;

  typedef enum logic { IX_IDX, IX_COUNT } idx_sel_e;

  typedef enum logic [1:0] { POS_ZERO, POS_ENTRY, POS_PLACE } pos_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_FIT, ST_GROW, ST_CHECK, ST_REP1, ST_COMMIT, ST_REP2
  } state_e;

  typedef struct packed {
    logic       load;
    place_sel_e sel;
    logic       idx_clr;
    logic       idx_inc;
    logic       grow_init;
    logic       grow_step;
    logic       t_clr;
    logic       t_upd;
    logic       commit_new;
    logic       commit_grow;
    logic       write_reloc;
    logic       emit;
    kind_e      kind;
    idx_sel_e   isel;
    pos_sel_e   psel;
    logic       last;
  } gcsp_cmd_t;

  typedef struct packed {
    logic match;
    logic idx_lt_count;
    logic full;
    logic fit;
    logic grow_bad;
    logic iter_last;
    logic out_free;
  } gcsp_stat_t;

  typedef struct packed {
    logic          fit;
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic [PW-1:0] cx;
    logic [PW-1:0] cy;
    logic [PW-1:0] sh;
  } place_t;

  function automatic place_t place_f(input logic [PW-1:0] cx, input logic [PW-1:0] cy,
                                     input logic [PW-1:0] sh, input logic [PW-1:0] wd,
                                     input logic [PW-1:0] ht, input logic [PW-1:0] w,
                                     input logic [PW-1:0] h);
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] s;
    place_t        r;
    x = cx;
    y = cy;
    s = sh;
    if (x + w + PW'(2) > wd) begin
      x = '0;
      y = y + sh + PW'(2);
      s = h;
    end else if (h > s) begin
      s = h;
    end
    r.fit = !((x + w + PW'(2) > wd) || (y + h + PW'(2) > ht));
    r.px  = x + PW'(1);
    r.py  = y + PW'(1);
    r.cx  = x + w + PW'(2);
    r.cy  = y;
    r.sh  = s;
    return r;
  endfunction

endpackage

[design/gcsp_ctrl.sv]
// Sequencer for search, placement, growth and the two repack passes.
module gcsp_ctrl import gcsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  gcsp_stat_t stat_i,
  output gcsp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = PS_CUR;
    cmd_o.kind = KIND_HIT;
    cmd_o.isel = IX_COUNT;
    cmd_o.psel = POS_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (stat_i.idx_lt_count) begin
          if (stat_i.match) begin
            cmd_o.kind = KIND_HIT;
            cmd_o.isel = IX_IDX;
            cmd_o.psel = POS_ENTRY;
            cmd_o.last = 1'b1;
            if (stat_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = ST_IDLE;
            end
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end else if (stat_i.full) begin
          cmd_o.kind = KIND_FULL;
          cmd_o.last = 1'b1;
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          state_d = ST_FIT;
        end
      end
      ST_FIT: begin
        cmd_o.sel = PS_CUR;
        if (stat_i.fit) begin
          cmd_o.kind = KIND_PLACED;
          cmd_o.psel = POS_PLACE;
          cmd_o.last = 1'b1;
          if (stat_i.out_free) begin
            cmd_o.emit       = 1'b1;
            cmd_o.commit_new = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          cmd_o.grow_init = 1'b1;
          state_d         = ST_GROW;
        end
      end
      ST_GROW: begin
        cmd_o.sel = PS_GROW;
        if (stat_i.fit || stat_i.iter_last) begin
          state_d = ST_CHECK;
        end else begin
          cmd_o.grow_step = 1'b1;
        end
      end
      ST_CHECK: begin
        cmd_o.sel = PS_GROW;
        if (!stat_i.fit || stat_i.grow_bad) begin
          cmd_o.kind = KIND_TOO_LARGE;
          cmd_o.last = 1'b1;
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          cmd_o.t_clr   = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_REP1;
        end
      end
      ST_REP1: begin
        // dry run: all old entries and then the new glyph must fit
        cmd_o.sel = stat_i.idx_lt_count ? PS_REP_ENTRY : PS_REP_NEW;
        if (!stat_i.fit) begin
          cmd_o.kind = KIND_REPACK_FAIL;
          cmd_o.last = 1'b1;
          if (stat_i.out_free) begin
            cmd_o.emit = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (stat_i.idx_lt_count) begin
          cmd_o.t_upd   = 1'b1;
          cmd_o.idx_inc = 1'b1;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit_grow = 1'b1;
        cmd_o.t_clr       = 1'b1;
        cmd_o.idx_clr     = 1'b1;
        state_d           = ST_REP2;
      end
      ST_REP2: begin
        cmd_o.psel = POS_PLACE;
        if (stat_i.idx_lt_count) begin
          cmd_o.sel  = PS_REP_ENTRY;
          cmd_o.kind = KIND_RELOC;
          cmd_o.isel = IX_IDX;
          if (stat_i.out_free) begin
            cmd_o.emit        = 1'b1;
            cmd_o.t_upd       = 1'b1;
            cmd_o.write_reloc = 1'b1;
            cmd_o.idx_inc     = 1'b1;
          end
        end else begin
          cmd_o.sel  = PS_REP_NEW;
          cmd_o.kind = KIND_PLACED;
          cmd_o.last = 1'b1;
          if (stat_i.out_free) begin
            cmd_o.emit       = 1'b1;
            cmd_o.commit_new = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[design/gcsp_dp.sv]
// Datapath: entry table, shelf cursor, atlas sides, placement unit and result register.
module gcsp_dp import gcsp_pkg::*; #(
  parameter int unsigned MAX_GLYPHS = DEF_MAX_GLYPHS,
  parameter int unsigned MAX_SIDE   = DEF_MAX_SIDE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFGI_W-1:0]    cfg_index_i,
  input  logic [SIDE_W-1:0]    cfg_data_i,
  input  logic [CODE_W-1:0]    glyph_code_i,
  input  logic [FONT_W-1:0]    font_index_i,
  input  logic [COLOR_W-1:0]   glyph_color_i,
  input  logic [DIM_W-1:0]     glyph_width_i,
  input  logic [DIM_W-1:0]     glyph_height_i,
  input  gcsp_cmd_t            cmd_i,
  output gcsp_stat_t           stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           result_kind_o,
  output logic [OIDX_W-1:0]    entry_index_o,
  output logic [SIDE_W-1:0]    x_pos_o,
  output logic [SIDE_W-1:0]    y_pos_o,
  output logic [SIDE_W-1:0]    atlas_width_o,
  output logic [SIDE_W-1:0]    atlas_height_o,
  output logic [GEN_W-1:0]     generation_o,
  output logic                 last_result_o
);

  localparam int unsigned IW = $clog2(MAX_GLYPHS + 1);
  localparam int unsigned AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

  logic [CODE_W-1:0]  entry_glyph  [MAX_GLYPHS];
  logic [FONT_W-1:0]  entry_font   [MAX_GLYPHS];
  logic [COLOR_W-1:0] entry_color  [MAX_GLYPHS];
  logic [DIM_W-1:0]   entry_width  [MAX_GLYPHS];
  logic [DIM_W-1:0]   entry_height [MAX_GLYPHS];
  logic [SIDE_W-1:0]  entry_x      [MAX_GLYPHS];
  logic [SIDE_W-1:0]  entry_y      [MAX_GLYPHS];

  logic [CODE_W-1:0]  code_q;
  logic [FONT_W-1:0]  font_q;
  logic [COLOR_W-1:0] color_q;
  logic [DIM_W-1:0]   w_q, h_q;

  logic [SIDE_W-1:0]  cur_w_q, cur_h_q;
  logic               mono_q;
  logic [IW-1:0]      count_q, idx_q;
  logic [SIDE_W-1:0]  cx_q, cy_q;
  logic [DIM_W-1:0]   sh_q;
  logic [GEN_W-1:0]   gen_q;
  logic [PW-1:0]      nw_q, nh_q, tcx_q, tcy_q, tsh_q;
  logic [3:0]         iter_q;

  logic [AW-1:0]      ra, wa;
  place_t             pl;
  logic [PW-1:0]      p_cx, p_cy, p_sh, p_wd, p_ht, p_w, p_h;

  assign ra = idx_q[AW-1:0];
  assign wa = count_q[AW-1:0];

  always_comb begin
    unique case (cmd_i.sel)
      PS_CUR: begin
        p_cx = PW'(cx_q);   p_cy = PW'(cy_q);   p_sh = PW'(sh_q);
        p_wd = PW'(cur_w_q); p_ht = PW'(cur_h_q);
        p_w  = PW'(w_q);    p_h  = PW'(h_q);
      end
      PS_GROW: begin
        p_cx = PW'(cx_q);   p_cy = PW'(cy_q);   p_sh = PW'(sh_q);
        p_wd = nw_q;        p_ht = nh_q;
        p_w  = PW'(w_q);    p_h  = PW'(h_q);
      end
      PS_REP_ENTRY: begin
        p_cx = tcx_q;       p_cy = tcy_q;       p_sh = tsh_q;
        p_wd = nw_q;        p_ht = nh_q;
        p_w  = PW'(entry_width[ra]);
        p_h  = PW'(entry_height[ra]);
      end
      default: begin
        p_cx = tcx_q;       p_cy = tcy_q;       p_sh = tsh_q;
        p_wd = nw_q;        p_ht = nh_q;
        p_w  = PW'(w_q);    p_h  = PW'(h_q);
      end
    endcase
    pl = place_f(p_cx, p_cy, p_sh, p_wd, p_ht, p_w, p_h);
  end

  always_comb begin
    stat_o.match        = (entry_glyph[ra] == code_q) && (entry_font[ra] == font_q) &&
                          (mono_q || (entry_color[ra] == color_q));
    stat_o.idx_lt_count = idx_q < count_q;
    stat_o.full         = count_q == IW'(MAX_GLYPHS);
    stat_o.fit          = pl.fit;
    stat_o.grow_bad     = (nw_q > PW'(MAX_SIDE)) || (nh_q > PW'(MAX_SIDE));
    stat_o.iter_last    = iter_q == LAST_ITER;
    stat_o.out_free     = !out_valid_o || out_ready_i;
  end

  // request capture and table contents: no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q  <= glyph_code_i;
      font_q  <= font_index_i;
      color_q <= glyph_color_i;
      w_q     <= glyph_width_i;
      h_q     <= glyph_height_i;
    end
    if (cmd_i.commit_new) begin
      entry_glyph[wa]  <= code_q;
      entry_font[wa]   <= font_q;
      entry_color[wa]  <= color_q;
      entry_width[wa]  <= w_q;
      entry_height[wa] <= h_q;
      entry_x[wa]      <= pl.px[SIDE_W-1:0];
      entry_y[wa]      <= pl.py[SIDE_W-1:0];
    end
    if (cmd_i.write_reloc) begin
      entry_x[ra] <= pl.px[SIDE_W-1:0];
      entry_y[ra] <= pl.py[SIDE_W-1:0];
    end
    if (cmd_i.grow_init) begin
      nw_q   <= PW'(cur_w_q);
      nh_q   <= PW'(cur_h_q);
      iter_q <= '0;
    end else if (cmd_i.grow_step) begin
      nw_q   <= {nw_q[PW-2:0], 1'b0};
      nh_q   <= {nh_q[PW-2:0], 1'b0};
      iter_q <= iter_q + 4'd1;
    end
    if (cmd_i.t_clr) begin
      tcx_q <= '0;
      tcy_q <= '0;
      tsh_q <= '0;
    end else if (cmd_i.t_upd) begin
      tcx_q <= pl.cx;
      tcy_q <= pl.cy;
      tsh_q <= pl.sh;
    end
  end

  // the initial side registers only matter while the table is empty, so they
  // load the current sides directly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mono_q   <= 1'b0;
      cur_w_q  <= RESET_SIDE;
      cur_h_q  <= RESET_SIDE;
      count_q  <= '0;
      idx_q    <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      sh_q     <= '0;
      gen_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_INIT_W: begin
            if (count_q == '0) cur_w_q <= cfg_data_i;
          end
          REG_INIT_H: begin
            if (count_q == '0) cur_h_q <= cfg_data_i;
          end
          REG_MONO: mono_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.commit_new) begin
        count_q <= count_q + IW'(1);
        cx_q    <= pl.cx[SIDE_W-1:0];
        cy_q    <= pl.cy[SIDE_W-1:0];
        sh_q    <= pl.sh[DIM_W-1:0];
      end
      if (cmd_i.commit_grow) begin
        cur_w_q <= nw_q[SIDE_W-1:0];
        cur_h_q <= nh_q[SIDE_W-1:0];
        gen_q   <= gen_q + GEN_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_kind_o  <= cmd_i.kind;
      entry_index_o  <= (cmd_i.isel == IX_IDX) ? OIDX_W'(idx_q) : OIDX_W'(count_q);
      unique case (cmd_i.psel)
        POS_ENTRY: begin
          x_pos_o <= entry_x[ra];
          y_pos_o <= entry_y[ra];
        end
        POS_PLACE: begin
          x_pos_o <= pl.px[SIDE_W-1:0];
          y_pos_o <= pl.py[SIDE_W-1:0];
        end
        default: begin
          x_pos_o <= '0;
          y_pos_o <= '0;
        end
      endcase
      atlas_width_o  <= cur_w_q;
      atlas_height_o <= cur_h_q;
      generation_o   <= gen_q;
      last_result_o  <= cmd_i.last;
    end
  end

endmodule

[design/glyph_cache_shelf_packer.sv]
// Top level of the glyph cache with shelf packing into a growing texture atlas.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+------------------------
//  config  | cfg_valid_i cfg_ready_o cfg_index_i/data  | cfg_valid_i & ready
//  request | in_valid_i in_ready_o glyph_* font_index  | in_valid_i & in_ready_o
//  result  | out_valid_o out_ready_i result_kind_o ... | out_valid_o & ready
//
// A hit ends the search of the entry table at its index; a plain miss searches the whole
// table and then tries the current shelf; a miss that grows the atlas doubles both sides
// until the glyph fits or the last iteration, checks them, makes a dry-run table pass,
// commits the new sides and relocates the entries; the one placement unit serves all.
// Each result sits in an output register; a stalled result stalls the sequencer.
// After reset the table is empty and the atlas is 256 by 256; no clearing pass.
module glyph_cache_shelf_packer import gcsp_pkg::*; #(
  parameter int unsigned MAX_GLYPHS = DEF_MAX_GLYPHS,
  parameter int unsigned MAX_SIDE   = DEF_MAX_SIDE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFGI_W-1:0]  cfg_index_i,
  input  logic [SIDE_W-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CODE_W-1:0]  glyph_code_i,
  input  logic [FONT_W-1:0]  font_index_i,
  input  logic [COLOR_W-1:0] glyph_color_i,
  input  logic [DIM_W-1:0]   glyph_width_i,
  input  logic [DIM_W-1:0]   glyph_height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         result_kind_o,
  output logic [OIDX_W-1:0]  entry_index_o,
  output logic [SIDE_W-1:0]  x_pos_o,
  output logic [SIDE_W-1:0]  y_pos_o,
  output logic [SIDE_W-1:0]  atlas_width_o,
  output logic [SIDE_W-1:0]  atlas_height_o,
  output logic [GEN_W-1:0]   generation_o,
  output logic               last_result_o
);

  gcsp_cmd_t  cmd;
  gcsp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  gcsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gcsp_dp #(
    .MAX_GLYPHS (MAX_GLYPHS),
    .MAX_SIDE   (MAX_SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .glyph_code_i   (glyph_code_i),
    .font_index_i   (font_index_i),
    .glyph_color_i  (glyph_color_i),
    .glyph_width_i  (glyph_width_i),
    .glyph_height_i (glyph_height_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .entry_index_o  (entry_index_o),
    .x_pos_o        (x_pos_o),
    .y_pos_o        (y_pos_o),
    .atlas_width_o  (atlas_width_o),
    .atlas_height_o (atlas_height_o),
    .generation_o   (generation_o),
    .last_result_o  (last_result_o)
  );

endmodule
